// ===== rtl/core/bprm_pkg.sv =====
// Package: opcodes, configuration indexes and defaults for the bound-pointer register machine.
`default_nettype none

package bprm_pkg;

   localparam int NUM_REGS_DEFAULT   = 6;
   localparam int DATA_WIDTH_DEFAULT = 32;

   localparam int OPERAND_WIDTH   = 32;
   localparam int OPCODE_WIDTH    = 4;
   localparam int DEST_WIDTH      = 3;
   localparam int PREG_WIDTH      = 3;
   localparam int LENGTH_WIDTH    = 16;
   localparam int CSR_INDEX_WIDTH = 2;
   localparam int CSR_DATA_WIDTH  = 16;

   localparam logic [LENGTH_WIDTH-1:0] LENGTH_RESET = 16'd36;
   localparam logic [PREG_WIDTH-1:0]   PREG_RESET   = 3'd0;

   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_POINTER_REGISTER = 2'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_PROGRAM_LENGTH   = 2'd1;

   typedef enum logic [OPCODE_WIDTH-1:0] {
      OP_ADDR = 4'd0,
      OP_ADDI = 4'd1,
      OP_MULR = 4'd2,
      OP_MULI = 4'd3,
      OP_BANR = 4'd4,
      OP_BANI = 4'd5,
      OP_BORR = 4'd6,
      OP_BORI = 4'd7,
      OP_SETR = 4'd8,
      OP_SETI = 4'd9,
      OP_GTIR = 4'd10,
      OP_GTRI = 4'd11,
      OP_GTRR = 4'd12,
      OP_EQIR = 4'd13,
      OP_EQRI = 4'd14,
      OP_EQRR = 4'd15
   } opcode_type;

endpackage

`default_nettype wire

// ===== rtl/core/bound_pointer_register_machine_unit.sv =====
// Top level: execute core of a register machine with the instruction pointer bound to a register.
//
// Usage: instructions arrive on the req_ channel (opcode, operand_a, operand_b, dest_index),
// fetched by the user at the pointer last reported on rsp_next_pointer. Each transfer gives
// exactly one result on the rsp_ channel: next pointer, register 0, halted and bad_index.
// The csr_ channel writes pointer_register (index 0) and program_length (index 1); it is
// always ready, and the user must write it only while no instruction is in flight: the
// block itself does not enforce this. A req transfer enters the input register, executes,
// and lands in the result register that drives rsp_valid. Throughput: one instruction per
// cycle unless the receiver stalls; the register file update and single multiplier act in execute.
// When the receiver stalls, the result register holds and the input register fills;
// req_ready drops only when both are full, so no transfer is lost.
// Reset (synchronous, active high) clears the register file and the pointer to zero,
// sets pointer_register to 0 and program_length to 36, and empties both stages.
// The halted flag is only reported; later instructions execute normally.
`default_nettype none

module bound_pointer_register_machine_unit
   import bprm_pkg::*;
#(
   parameter int NUM_REGS   = NUM_REGS_DEFAULT,
   parameter int DATA_WIDTH = DATA_WIDTH_DEFAULT
) (
   input  wire                              clock,
   input  wire                              reset,

   input  wire                              req_valid,
   output logic                             req_ready,
   input  wire  [OPCODE_WIDTH-1:0]          req_opcode,
   input  wire  signed [OPERAND_WIDTH-1:0]  req_operand_a,
   input  wire  signed [OPERAND_WIDTH-1:0]  req_operand_b,
   input  wire  [DEST_WIDTH-1:0]            req_dest_index,

   output logic                             rsp_valid,
   input  wire                              rsp_ready,
   output logic signed [OPERAND_WIDTH-1:0]  rsp_next_pointer,
   output logic signed [OPERAND_WIDTH-1:0]  rsp_first_register,
   output logic                             rsp_halted,
   output logic                             rsp_bad_index,

   input  wire                              csr_valid,
   output logic                             csr_ready,
   input  wire  [CSR_INDEX_WIDTH-1:0]       csr_index,
   input  wire  [CSR_DATA_WIDTH-1:0]        csr_data
);

   localparam int IDX_W = $clog2(NUM_REGS);

   // configuration
   logic [PREG_WIDTH-1:0]   preg_ff;
   logic [LENGTH_WIDTH-1:0] length_ff;

   // architectural state
   logic [DATA_WIDTH-1:0] rf_ff [NUM_REGS];
   logic [DATA_WIDTH-1:0] rf_in [NUM_REGS];
   logic [DATA_WIDTH-1:0] pointer_ff;
   logic [DATA_WIDTH-1:0] pointer_in;

   // input stage
   logic                            s1_valid_ff;
   opcode_type                      s1_op_ff;
   logic signed [OPERAND_WIDTH-1:0] s1_a_ff;
   logic signed [OPERAND_WIDTH-1:0] s1_b_ff;
   logic [DEST_WIDTH-1:0]           s1_c_ff;

   // result stage
   logic                            rsp_valid_ff;
   logic signed [OPERAND_WIDTH-1:0] rsp_next_ff;
   logic signed [OPERAND_WIDTH-1:0] rsp_first_ff;
   logic                            rsp_halted_ff;
   logic                            rsp_bad_ff;

   logic exec_fire;
   logic req_fire;

   // execute datapath
   logic [DATA_WIDTH-1:0]    rf_eff [NUM_REGS];
   logic [OPERAND_WIDTH-1:0] preg_ext;
   logic [OPERAND_WIDTH-1:0] dest_ext;
   logic [IDX_W-1:0]         preg_sel;
   logic [IDX_W-1:0]         a_sel;
   logic [IDX_W-1:0]         b_sel;
   logic [IDX_W-1:0]         c_sel;
   logic                     bound;
   logic                     a_ok;
   logic                     b_ok;
   logic                     c_ok;
   logic                     chk_a;
   logic                     chk_b;
   logic                     bad;
   logic signed [DATA_WIDTH-1:0] ra;
   logic signed [DATA_WIDTH-1:0] rb;
   logic signed [DATA_WIDTH-1:0] ia;
   logic signed [DATA_WIDTH-1:0] ib;
   logic signed [DATA_WIDTH-1:0] mul_y;
   logic [DATA_WIDTH-1:0]        prod;
   logic [DATA_WIDTH-1:0]        r;
   logic [DATA_WIDTH-1:0]        bound_final;
   logic signed [DATA_WIDTH-1:0] first_final;
   logic signed [DATA_WIDTH-1:0] next_s;
   logic                         halted_in;

   assign exec_fire = s1_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready = !s1_valid_ff || exec_fire;
   assign req_fire  = req_valid && req_ready;
   assign csr_ready = 1'b1;

   assign preg_ext = OPERAND_WIDTH'(preg_ff);
   assign dest_ext = OPERAND_WIDTH'(s1_c_ff);
   assign preg_sel = preg_ext[IDX_W-1:0];
   assign a_sel    = s1_a_ff[IDX_W-1:0];
   assign b_sel    = s1_b_ff[IDX_W-1:0];
   assign c_sel    = dest_ext[IDX_W-1:0];
   assign bound    = preg_ext < OPERAND_WIDTH'(NUM_REGS);
   assign a_ok     = $unsigned(s1_a_ff) < OPERAND_WIDTH'(NUM_REGS);
   assign b_ok     = $unsigned(s1_b_ff) < OPERAND_WIDTH'(NUM_REGS);
   assign c_ok     = dest_ext < OPERAND_WIDTH'(NUM_REGS);
   assign ia       = DATA_WIDTH'(s1_a_ff);
   assign ib       = DATA_WIDTH'(s1_b_ff);

   // bound register sees the pointer before execution
   always_comb begin
      for (int i = 0; i < NUM_REGS; i++) begin
         rf_eff[i] = (bound && preg_sel == IDX_W'(i)) ? pointer_ff : rf_ff[i];
      end
   end

   assign ra = a_ok ? rf_eff[a_sel] : '0;
   assign rb = b_ok ? rf_eff[b_sel] : '0;

   always_comb begin
      case (s1_op_ff)
         OP_MULR: mul_y = rb;
         default: mul_y = ib;
      endcase
   end

   assign prod = ra * mul_y;

   always_comb begin
      chk_a = 1'b0;
      chk_b = 1'b0;
      r     = '0;
      case (s1_op_ff)
         OP_ADDR: begin chk_a = 1'b1; chk_b = 1'b1; r = ra + rb; end
         OP_ADDI: begin chk_a = 1'b1; r = ra + ib; end
         OP_MULR: begin chk_a = 1'b1; chk_b = 1'b1; r = prod; end
         OP_MULI: begin chk_a = 1'b1; r = prod; end
         OP_BANR: begin chk_a = 1'b1; chk_b = 1'b1; r = ra & rb; end
         OP_BANI: begin chk_a = 1'b1; r = ra & ib; end
         OP_BORR: begin chk_a = 1'b1; chk_b = 1'b1; r = ra | rb; end
         OP_BORI: begin chk_a = 1'b1; r = ra | ib; end
         OP_SETR: begin chk_a = 1'b1; r = ra; end
         OP_SETI: begin r = ia; end
         OP_GTIR: begin chk_b = 1'b1; r = DATA_WIDTH'(ia > rb); end
         OP_GTRI: begin chk_a = 1'b1; r = DATA_WIDTH'(ra > ib); end
         OP_GTRR: begin chk_a = 1'b1; chk_b = 1'b1; r = DATA_WIDTH'(ra > rb); end
         OP_EQIR: begin chk_b = 1'b1; r = DATA_WIDTH'(ia == rb); end
         OP_EQRI: begin chk_a = 1'b1; r = DATA_WIDTH'(ra == ib); end
         OP_EQRR: begin chk_a = 1'b1; chk_b = 1'b1; r = DATA_WIDTH'(ra == rb); end
         default: begin chk_a = 1'b1; chk_b = 1'b1; r = DATA_WIDTH'(ra == rb); end
      endcase
   end

   assign bad = (chk_a && !a_ok) || (chk_b && !b_ok) || !c_ok;

   always_comb begin
      for (int i = 0; i < NUM_REGS; i++) begin
         rf_in[i] = (!bad && c_sel == IDX_W'(i)) ? r : rf_eff[i];
      end
   end

   assign bound_final = (!bad && c_sel == preg_sel) ? r : pointer_ff;
   assign pointer_in  = (bound ? bound_final : pointer_ff) + DATA_WIDTH'(1);
   assign first_final = rf_in[0];
   assign next_s      = pointer_in;
   assign halted_in   = pointer_in[DATA_WIDTH-1] || (pointer_in >= length_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         preg_ff      <= PREG_RESET;
         length_ff    <= LENGTH_RESET;
         pointer_ff   <= '0;
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < NUM_REGS; i++) begin
            rf_ff[i] <= '0;
         end
      end else begin
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_POINTER_REGISTER: preg_ff <= csr_data[PREG_WIDTH-1:0];
               CSR_PROGRAM_LENGTH:   length_ff <= csr_data[LENGTH_WIDTH-1:0];
               default: ;
            endcase
         end
         if (req_ready) begin
            s1_valid_ff <= req_valid;
         end
         if (exec_fire) begin
            pointer_ff <= pointer_in;
            for (int i = 0; i < NUM_REGS; i++) begin
               rf_ff[i] <= rf_in[i];
            end
         end
         if (exec_fire) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (req_fire) begin
         s1_op_ff <= opcode_type'(req_opcode);
         s1_a_ff  <= req_operand_a;
         s1_b_ff  <= req_operand_b;
         s1_c_ff  <= req_dest_index;
      end
      if (exec_fire) begin
         rsp_next_ff   <= OPERAND_WIDTH'(next_s);
         rsp_first_ff  <= OPERAND_WIDTH'(first_final);
         rsp_halted_ff <= halted_in;
         rsp_bad_ff    <= bad;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_next_pointer   = rsp_next_ff;
   assign rsp_first_register = rsp_first_ff;
   assign rsp_halted         = rsp_halted_ff;
   assign rsp_bad_index      = rsp_bad_ff;

   a_exec_gives_rsp: assert property (@(posedge clock) disable iff (reset)
      exec_fire |=> rsp_valid)
      else $error("execute transfer did not raise rsp_valid");

   a_stall_needs_full: assert property (@(posedge clock) disable iff (reset)
      !req_ready |-> (s1_valid_ff && rsp_valid_ff && !rsp_ready))
      else $error("req_ready low without a full pipeline");

   a_pointer_matches_rsp: assert property (@(posedge clock) disable iff (reset)
      exec_fire |=> (rsp_next_pointer == OPERAND_WIDTH'($signed(pointer_ff))))
      else $error("reported pointer differs from stored pointer");

   a_negative_halts: assert property (@(posedge clock) disable iff (reset)
      (exec_fire && pointer_in[DATA_WIDTH-1]) |=> rsp_halted)
      else $error("negative pointer not flagged as halted");

endmodule

`default_nettype wire
